@@ src/vgdm_pkg.sv @@
// vgdm_pkg: shared types and constants for the voxel grid duplicate marker.
// Used by vgdm_div_lane, vgdm_occ_map and voxel_grid_duplicate_marker.
// No dependencies.
package vgdm_pkg;

   localparam int CELL_SIZE_BITS = 23;
   localparam logic [CELL_SIZE_BITS-1:0] CELL_SIZE_RESET = 23'd256;
   localparam int INDEX_BITS = 24;
   localparam int AXES = 3;
   // log2 of the occupancy row width in bits
   localparam int MAP_ROW_LG = 6;

   typedef struct packed {
      logic done;
      logic in_range;
   } lane_status_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } map_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_UPDATE
   } ctrl_state_type;

endpackage

@@ src/vgdm_div_lane.sv @@
// vgdm_div_lane: one axis lane, floor division of a coordinate by the cell size,
// restoring, one quotient bit per cycle, with grid range check.
// Depends on vgdm_pkg.
module vgdm_div_lane import vgdm_pkg::*; #(
   parameter int GRID_BITS  = 6,
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic signed [COORD_BITS-1:0] coord,
   input  logic [CELL_SIZE_BITS-1:0]    size,
   output lane_status_type              status,
   output logic [GRID_BITS-1:0]         vox
);

   localparam int WIDE = (COORD_BITS > CELL_SIZE_BITS + GRID_BITS) ?
                         COORD_BITS : CELL_SIZE_BITS + GRID_BITS;
   localparam int TW = WIDE + 2;
   localparam int CW = $clog2(GRID_BITS);

   logic signed [COORD_BITS-1:0] coord_ff;
   logic [CELL_SIZE_BITS-1:0]    size_ff;
   logic signed [TW-1:0]         rem_ff, rem_in;
   logic signed [TW-1:0]         div_ff, div_in;
   logic [GRID_BITS-1:0]         quo_ff, quo_in;
   logic                         ok_ff, ok_in;
   logic [CW-1:0]                cnt_ff;
   logic                         prep_ff, active_ff, first_ff, done_ff;

   logic signed [TW-1:0] coord_ext, size_ext, diff;
   logic                 take;

   always_comb begin
      coord_ext = TW'(coord_ff);
      size_ext  = $signed(TW'(size_ff));
      diff      = rem_ff - div_ff;
      take      = !diff[TW-1];
      rem_in    = rem_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      ok_in     = ok_ff;
      if (prep_ff) begin
         // bias by half the grid so the quotient is the unsigned cell offset
         div_in = size_ext <<< (GRID_BITS - 1);
         rem_in = coord_ext + (size_ext <<< (GRID_BITS - 1));
      end else if (active_ff) begin
         if (first_ff) begin
            ok_in = !rem_ff[TW-1] && (rem_ff < (div_ff <<< 1));
         end
         rem_in = take ? diff : rem_ff;
         div_in = div_ff >>> 1;
         quo_in = {quo_ff[GRID_BITS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         coord_ff <= coord;
         size_ff  <= size;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      ok_ff  <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff   <= 1'b0;
         active_ff <= 1'b0;
         first_ff  <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            prep_ff   <= 1'b1;
            active_ff <= 1'b0;
         end else if (prep_ff) begin
            prep_ff   <= 1'b0;
            active_ff <= 1'b1;
            first_ff  <= 1'b1;
            cnt_ff    <= CW'(GRID_BITS - 1);
         end else if (active_ff) begin
            first_ff <= 1'b0;
            if (cnt_ff == '0) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign status.done     = done_ff;
   assign status.in_range = ok_ff;
   assign vox             = quo_ff;

endmodule

@@ src/vgdm_occ_map.sv @@
// vgdm_occ_map: occupancy bitmap held as a memory of rows, with a clearing
// sweep after reset and a read-then-set port for one bit.
// Depends on vgdm_pkg.
module vgdm_occ_map import vgdm_pkg::*; #(
   parameter int GRID_BITS = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  map_cmd_type              cmd,
   input  logic [3*GRID_BITS-1:0]   addr,
   output logic                     ready,
   output logic                     hit
);

   localparam int AB       = 3 * GRID_BITS;
   localparam int ROW_LG   = (AB > MAP_ROW_LG + 1) ? MAP_ROW_LG : AB - 1;
   localparam int ROW_BITS = 1 << ROW_LG;
   localparam int RW       = AB - ROW_LG;
   localparam int ROWS     = 1 << RW;

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] row_q_ff;
   logic [ROW_LG-1:0]   off_ff;
   logic [RW-1:0]       clr_cnt_ff;
   logic                clearing_ff;

   logic [RW-1:0]       row_sel;
   logic [ROW_LG-1:0]   off_sel;
   logic [ROW_BITS-1:0] bit_mask;

   assign row_sel  = addr[AB-1:ROW_LG];
   assign off_sel  = addr[ROW_LG-1:0];
   assign bit_mask = ROW_BITS'(1) << off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (&clr_cnt_ff) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // single write port: sweep first, then set bits on the row read before
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.wr) begin
         mem[row_sel] <= row_q_ff | bit_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         row_q_ff <= mem[row_sel];
         off_ff   <= off_sel;
      end
   end

   assign ready = !clearing_ff;
   assign hit   = row_q_ff[off_ff];

endmodule

@@ src/voxel_grid_duplicate_marker.sv @@
// voxel_grid_duplicate_marker: top level, three division lanes, occupancy map
// and the controller that merges the lanes and sequences each transaction.
// Depends on vgdm_pkg, vgdm_div_lane and vgdm_occ_map.
//
// Usage:
//   A point is taken when start is high and busy is low. Its coordinates are
//   signed fixed point with 8 fraction bits; point_index is passed through.
//   Each point gives exactly one result, shown for one cycle with rsp_valid
//   high: remove is set when the point's voxel was already occupied,
//   out_of_range when the voxel lies outside the grid (such a point is kept
//   and not recorded). The receiver cannot stall; results must be taken.
//   cell_size is written through csr_wr_en / csr_wr_data; the user must do so only while busy is low (not enforced).
// Sequencing:
//   An out-of-grid point is answered after the lanes' divide loop, one
//   quotient bit per cycle; an in-grid point then adds one read and one
//   write of the occupancy row memory. A new point is taken in the cycle
//   the result is shown.
// Reset:
//   reset clears control state, sets cell_size to 1.0 and starts a sweep
//   that clears the occupancy memory, one row a cycle, over its
//   2^(3*GRID_BITS-6) rows (4096 at the default), with busy high throughout.
module voxel_grid_duplicate_marker import vgdm_pkg::*; #(
   parameter int GRID_BITS  = 6,
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   input  logic [INDEX_BITS-1:0]        req_point_index,
   output logic                         rsp_valid,
   output logic [INDEX_BITS-1:0]        rsp_out_index,
   output logic                         rsp_remove,
   output logic                         rsp_out_of_range,
   input  logic                         csr_wr_en,
   input  logic [CELL_SIZE_BITS-1:0]    csr_wr_data
);

   ctrl_state_type state_ff, state_in;

   logic [CELL_SIZE_BITS-1:0] cell_size_ff;
   logic [INDEX_BITS-1:0]     index_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_remove_ff, rsp_remove_in;
   logic                      rsp_oor_ff, rsp_oor_in;
   logic [INDEX_BITS-1:0]     rsp_index_ff;

   logic                         accept;
   logic                         in_grid;
   logic                         lanes_done;
   lane_status_type              lane_st    [AXES];
   logic [GRID_BITS-1:0]         lane_vox   [AXES];
   logic signed [COORD_BITS-1:0] lane_coord [AXES];

   map_cmd_type                  map_cmd;
   logic                         map_ready;
   logic                         map_hit;
   logic [3*GRID_BITS-1:0]       map_addr;

   assign accept        = start && !busy;
   assign busy          = (state_ff != ST_IDLE);
   assign lane_coord[0] = req_coord_x;
   assign lane_coord[1] = req_coord_y;
   assign lane_coord[2] = req_coord_z;

   for (genvar i = 0; i < AXES; i++) begin : g_lane
      vgdm_div_lane #(
         .GRID_BITS  (GRID_BITS),
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .load   (accept),
         .coord  (lane_coord[i]),
         .size   (cell_size_ff),
         .status (lane_st[i]),
         .vox    (lane_vox[i])
      );
   end

   // merge: all lanes run in lockstep, the point is in the grid only if every
   // axis is; cell size zero fails every range check in the lanes
   assign lanes_done = lane_st[0].done;
   assign in_grid    = lane_st[0].in_range && lane_st[1].in_range &&
                       lane_st[2].in_range;
   assign map_addr   = {lane_vox[0], lane_vox[1], lane_vox[2]};

   vgdm_occ_map #(
      .GRID_BITS (GRID_BITS)
   ) u_map (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .addr  (map_addr),
      .ready (map_ready),
      .hit   (map_hit)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (map_ready) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (lanes_done) state_in = in_grid ? ST_LOOKUP : ST_IDLE;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      map_cmd.rd    = (state_ff == ST_LOOKUP);
      map_cmd.wr    = (state_ff == ST_UPDATE);
      rsp_oor_in    = (state_ff == ST_DIVIDE) && lanes_done && !in_grid;
      rsp_remove_in = (state_ff == ST_UPDATE) && map_hit;
      rsp_valid_in  = rsp_oor_in || (state_ff == ST_UPDATE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cell_size_ff <= CELL_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cell_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         index_ff <= req_point_index;
      end
      if (rsp_valid_in) begin
         rsp_index_ff  <= index_ff;
         rsp_remove_ff <= rsp_remove_in;
         rsp_oor_ff    <= rsp_oor_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_index    = rsp_index_ff;
   assign rsp_remove       = rsp_remove_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      lanes_done |-> state_ff == ST_DIVIDE)
      else $error("lane finished outside the divide state");

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_st[0].done == lane_st[1].done && lane_st[0].done == lane_st[2].done)
      else $error("division lanes out of step");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_remove && rsp_out_of_range))
      else $error("transaction both removed and out of range");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      map_cmd.wr |-> $past(map_cmd.rd))
      else $error("occupancy write without preceding read");

   a_map_cleared: assert property (@(posedge clock) disable iff (reset)
      map_cmd.rd |-> map_ready)
      else $error("occupancy read during clearing sweep");

endmodule
